// ----- src/chained_hash_table_top_defines.svh -----
// Assertion macros shared by the hash table RTL.
// Each macro expects a clock named clk and a reset named rst in scope.
`ifndef CHAINED_HASH_TABLE_TOP_DEFINES_SVH
`define CHAINED_HASH_TABLE_TOP_DEFINES_SVH

// Same-cycle implication, inactive during reset.
`define CHT_ASSERT_NOW(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("hash table check failed");

// Next-cycle implication, inactive during reset.
`define CHT_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("hash table check failed");

`endif

// ----- src/cht_pkg.sv -----
// ----------------------------------------------------------------------------
// cht_pkg
// Shared types and constants of the chained hash table.
// ----------------------------------------------------------------------------
package cht_pkg;

  localparam int KEY_W    = 31;
  localparam int VAL_W    = 32;
  localparam int EMPTY_W  = 10;
  localparam int COUNT_W  = 11;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_LOOKUP = 2'd1,
    ACT_STATS  = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_MISSING = 2'd1,
    STS_FULL    = 2'd2,
    STS_UNUSED  = 2'd3
  } status_t;

endpackage

// ----- src/cht_mod.sv -----
// ----------------------------------------------------------------------------
// cht_mod
// Key-mod-BUCKETS unit by reciprocal multiplication.
// ----------------------------------------------------------------------------
module cht_mod import cht_pkg::*; #(
  parameter int BUCKETS = 512
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  input  logic [KEY_W-1:0]                      key,
  output logic                                  done,
  output logic [(BUCKETS > 1 ? $clog2(BUCKETS) : 1)-1:0] bucket
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  // The reciprocal is scaled by 2**SHIFT and rounded up, which makes the
  // quotient exact for every key of KEY_W bits.
  localparam int SHIFT = KEY_W + ((BUCKETS > 1) ? $clog2(BUCKETS) : 0);
  localparam logic [63:0] RECIP =
    ((64'd1 << SHIFT) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam int LO_W = 17;
  localparam int HI_W = 15;
  localparam logic [LO_W-1:0] RECIP_LO = RECIP[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP[LO_W+HI_W-1:LO_W];
  localparam logic [BW:0]     DIVISOR  = (BW + 1)'(BUCKETS);

  logic [KEY_W-1:0]      key_q;
  logic [KEY_W+LO_W-1:0] prod_lo;
  logic [KEY_W+HI_W-1:0] prod_hi;
  logic [63:0]           prod;
  logic [63:0]           prod_sh;
  logic [KEY_W-1:0]      quot;
  logic [KEY_W-1:0]      diff;
  logic [BW-1:0]         rem;
  logic [2:0]            stage;

  // Join the partial products, take the quotient and the remainder.
  always_comb begin
    prod    = 64'(prod_lo) + (64'(prod_hi) << LO_W);
    prod_sh = prod >> SHIFT;
    diff    = key_q - KEY_W'(quot * DIVISOR);
  end

  // Step sequencer: key, partial products, quotient, remainder.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      done  <= stage[2];
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    if (start) begin
      key_q <= key;
    end
    prod_lo <= key_q * RECIP_LO;
    prod_hi <= key_q * RECIP_HI;
    quot    <= prod_sh[KEY_W-1:0];
    rem     <= diff[BW-1:0];
  end

  assign bucket = rem;

endmodule

// ----- src/chained_hash_table_top.sv -----
// ----------------------------------------------------------------------------
// chained_hash_table_top
// Separate-chaining hash table over a fixed node pool, bucket = key mod BUCKETS.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one item: action, key, value.
//   Insert appends key/value to its bucket chain, lookup returns the value of
//   the earliest matching key, stats reports empty buckets, entries and the
//   longest chain. Every item yields exactly one result item on the output
//   channel (out_valid/out_stall).
//   Insert hashes the key, reads the bucket and, when its chain is not empty,
//   links the new node to the old tail; lookup hashes, reads the bucket and
//   visits chain nodes; stats scans every bucket; a full insert or an unused
//   action goes straight to the result. The bucket memories are read once a cycle
//   during a stats scan and the pool memory once a cycle during a chain walk.
//   One item is worked on at a time; a new item is taken in the cycle after the
//   previous one has its result in the output register.
//   After reset the block clears every entry of the bucket length memory
//   and holds in_stall high meanwhile.
//   When the receiver stalls, the result holds in the output register and a
//   following result waits inside the block until the register frees.
// ----------------------------------------------------------------------------
`include "chained_hash_table_top_defines.svh"

module chained_hash_table_top import cht_pkg::*; #(
  parameter int BUCKETS    = 512,
  parameter int POOL_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [1:0]                 action,
  input  logic [KEY_W-1:0]           key,
  input  logic signed [VAL_W-1:0]    value,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [1:0]                 status,
  output logic signed [VAL_W-1:0]    found_value,
  output logic [EMPTY_W-1:0]         empty_buckets,
  output logic [COUNT_W-1:0]         total_entries,
  output logic [COUNT_W-1:0]         longest_chain
);

  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int NW = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int CW = $clog2(POOL_DEPTH + 1);
  localparam int EW = $clog2(BUCKETS + 1);
  localparam logic [BW-1:0] LAST_BUCKET = BW'(BUCKETS - 1);
  localparam logic [CW-1:0] POOL_FULL   = CW'(POOL_DEPTH);

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_HASH, ST_BKT_RD, ST_BKT, ST_LINK,
    ST_NODE, ST_STAT, ST_STAT_END, ST_RESP
  } state_t;

  state_t state;

  // Item registers.
  action_t           act;
  logic [KEY_W-1:0]  key_sv;
  logic [VAL_W-1:0]  val_sv;
  logic [BW-1:0]     bkt;
  logic [NW-1:0]     tail_sv;
  logic [CW-1:0]     used;
  logic [BW-1:0]     scan;
  logic              stat_vld;
  logic [EW-1:0]     empt;
  logic [CW-1:0]     lng;

  // Pending result.
  status_t           res_status;
  logic [VAL_W-1:0]  res_found;
  logic [EW-1:0]     res_empt;
  logic [CW-1:0]     res_total;
  logic [CW-1:0]     res_lng;

  // Memories: per-bucket length, head and tail; per-node key, value and link.
  logic [CW-1:0]    len_mem  [BUCKETS];
  logic [NW-1:0]    head_mem [BUCKETS];
  logic [NW-1:0]    tail_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [POOL_DEPTH];
  logic [VAL_W-1:0] val_mem  [POOL_DEPTH];
  logic [CW-1:0]    link_mem [POOL_DEPTH];

  logic [CW-1:0]    len_rd;
  logic [NW-1:0]    head_rd;
  logic [NW-1:0]    tail_rd;
  logic [KEY_W-1:0] key_rd;
  logic [VAL_W-1:0] val_rd;
  logic [CW-1:0]    link_rd;

  logic [BW-1:0]    bkt_ra;
  logic [NW-1:0]    nd_ra;
  logic             len_we;
  logic [BW-1:0]    len_wa;
  logic [CW-1:0]    len_wd;
  logic             ends_we;
  logic             head_we;
  logic             node_we;
  logic             link_we;
  logic [NW-1:0]    link_wa;
  logic [CW-1:0]    link_wd;
  logic [NW-1:0]    new_node;
  logic [CW-1:0]    link_nxt;
  logic             out_free;

  logic             hash_start;
  logic             hash_done;
  logic [BW-1:0]    hash_bkt;

  cht_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk    (clk),
    .rst    (rst),
    .start  (hash_start),
    .key    (key_sv),
    .done   (hash_done),
    .bucket (hash_bkt)
  );

  assign in_stall = (state != ST_IDLE);
  assign new_node = used[NW-1:0];
  assign link_nxt = link_rd - 1'b1;
  assign out_free = !out_valid || !out_stall;

  // Memory addresses and write strobes.
  always_comb begin
    bkt_ra  = bkt;
    nd_ra   = head_rd;
    len_we  = 1'b0;
    len_wa  = bkt;
    len_wd  = len_rd + 1'b1;
    ends_we = 1'b0;
    head_we = 1'b0;
    node_we = 1'b0;
    link_we = 1'b0;
    link_wa = new_node;
    link_wd = '0;
    case (state)
      ST_CLEAR: begin
        len_we = 1'b1;
        len_wa = scan;
        len_wd = '0;
      end
      ST_STAT: begin
        bkt_ra = scan;
      end
      ST_BKT: begin
        if (act == ACT_INSERT) begin
          len_we  = 1'b1;
          ends_we = 1'b1;
          head_we = (len_rd == '0);
          node_we = 1'b1;
          link_we = 1'b1;
        end
      end
      ST_LINK: begin
        link_we = 1'b1;
        link_wa = tail_sv;
        link_wd = used;
      end
      ST_NODE: begin
        nd_ra = link_nxt[NW-1:0];
      end
      default: begin
      end
    endcase
  end

  // Bucket memories.
  always_ff @(posedge clk) begin
    if (len_we) begin
      len_mem[len_wa] <= len_wd;
    end
    if (ends_we) begin
      tail_mem[bkt] <= new_node;
    end
    if (head_we) begin
      head_mem[bkt] <= new_node;
    end
    len_rd  <= len_mem[bkt_ra];
    head_rd <= head_mem[bkt_ra];
    tail_rd <= tail_mem[bkt_ra];
  end

  // Node pool memories.
  always_ff @(posedge clk) begin
    if (node_we) begin
      key_mem[new_node] <= key_sv;
      val_mem[new_node] <= val_sv;
    end
    if (link_we) begin
      link_mem[link_wa] <= link_wd;
    end
    key_rd  <= key_mem[nd_ra];
    val_rd  <= val_mem[nd_ra];
    link_rd <= link_mem[nd_ra];
  end

  // Controller and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      scan       <= '0;
      used       <= '0;
      stat_vld   <= 1'b0;
      hash_start <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      hash_start <= 1'b0;
      // Drop a taken result unless a new one is loaded in this cycle.
      if (out_valid && !out_stall && state != ST_RESP) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          scan <= scan + 1'b1;
          if (scan == LAST_BUCKET) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            act        <= action_t'(action);
            key_sv     <= key;
            val_sv     <= value;
            res_status <= STS_OK;
            res_found  <= '0;
            res_empt   <= '0;
            res_total  <= '0;
            res_lng    <= '0;
            case (action_t'(action))
              ACT_INSERT: begin
                if (used == POOL_FULL) begin
                  res_status <= STS_FULL;
                  state      <= ST_RESP;
                end else begin
                  hash_start <= 1'b1;
                  state      <= ST_HASH;
                end
              end
              ACT_LOOKUP: begin
                hash_start <= 1'b1;
                state      <= ST_HASH;
              end
              ACT_STATS: begin
                scan     <= '0;
                stat_vld <= 1'b0;
                empt     <= '0;
                lng      <= '0;
                state    <= ST_STAT;
              end
              default: begin
                state <= ST_RESP;
              end
            endcase
          end
        end
        ST_HASH: begin
          if (hash_done) begin
            bkt   <= hash_bkt;
            state <= ST_BKT_RD;
          end
        end
        ST_BKT_RD: begin
          state <= ST_BKT;
        end
        ST_BKT: begin
          if (act == ACT_INSERT) begin
            used    <= used + 1'b1;
            tail_sv <= tail_rd;
            state   <= (len_rd == '0) ? ST_RESP : ST_LINK;
          end else begin
            res_status <= STS_MISSING;
            state      <= (len_rd == '0) ? ST_RESP : ST_NODE;
          end
        end
        ST_LINK: begin
          state <= ST_RESP;
        end
        ST_NODE: begin
          // One chain node per cycle until a match or the chain end.
          if (key_rd == key_sv) begin
            res_status <= STS_OK;
            res_found  <= val_rd;
            state      <= ST_RESP;
          end else if (link_rd == '0) begin
            state <= ST_RESP;
          end
        end
        ST_STAT, ST_STAT_END: begin
          if (stat_vld) begin
            if (len_rd == '0) begin
              empt <= empt + 1'b1;
            end
            if (len_rd > lng) begin
              lng <= len_rd;
            end
          end
          if (state == ST_STAT) begin
            stat_vld <= 1'b1;
            scan     <= scan + 1'b1;
            if (scan == LAST_BUCKET) begin
              state <= ST_STAT_END;
            end
          end else begin
            res_empt  <= empt + EW'(len_rd == '0);
            res_lng   <= (len_rd > lng) ? len_rd : lng;
            res_total <= used;
            state     <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (out_free) begin
            out_valid     <= 1'b1;
            status        <= res_status;
            found_value   <= res_found;
            empty_buckets <= EMPTY_W'(res_empt);
            total_entries <= COUNT_W'(res_total);
            longest_chain <= COUNT_W'(res_lng);
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // The pool count never passes the pool size.
  `CHT_ASSERT_NOW(a_used_bound, 1'b1, used <= POOL_FULL)
  // A full report is only given when the pool is exhausted.
  `CHT_ASSERT_NOW(a_full_status, state == ST_RESP && res_status == STS_FULL, used == POOL_FULL)
  // Leaving the response state with a free output register presents the result and returns to idle.
  `CHT_ASSERT_NEXT(a_out_from_resp, state == ST_RESP && out_free, out_valid && state == ST_IDLE)
  // The hash unit reports completion only while the controller waits for it.
  `CHT_ASSERT_NOW(a_hash_done, hash_done, state == ST_HASH)

endmodule
